@@ sv/salru_pkg.sv @@
// Shared types and constants for the set-associative LRU hit/miss model.
package salru_pkg;

  // Fixed field widths of the transaction payloads
  localparam int unsigned IdW   = 16;
  localparam int unsigned SetW  = 4;
  localparam int unsigned MissW = 32;
  localparam int unsigned WaysW = 4;
  // Wide enough to hold any built way count (up to 63)
  localparam int unsigned CapW  = 6;

  // Configuration register map
  localparam logic             RegWaysInUse = 1'b0;
  localparam logic [WaysW-1:0] WaysReset    = 4'd8;

  localparam logic [MissW-1:0] MissMax = '1;

  typedef struct packed {
    logic [IdW-1:0]  access_id;
    logic [SetW-1:0] set_index;
    logic            last_access;
  } salru_req_t;

  typedef struct packed {
    logic             hit;
    logic [MissW-1:0] miss_total;
    logic             done_res;
  } salru_res_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } salru_cell_ctl_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } salru_state_e;

endpackage

@@ sv/salru_cell.sv @@
// One way of the recency chain: a per-set slot store, tag compare and shift-in.
module salru_cell #(
  parameter int unsigned SETS    = 16,
  parameter int unsigned ID_BITS = 16,
  parameter int unsigned IDX     = 0,
  parameter int unsigned AW      = 4
) (
  input  logic                          clk_i,
  input  salru_pkg::salru_cell_ctl_t    ctl_i,
  input  logic [AW-1:0]                 addr_i,
  input  logic [ID_BITS-1:0]            id_i,
  input  logic [salru_pkg::CapW-1:0]    cap_i,
  input  logic [ID_BITS-1:0]            prev_i,
  input  logic                          seen_i,
  output logic [ID_BITS-1:0]            data_o,
  output logic                          seen_o
);

  logic [ID_BITS-1:0] mem_q [SETS];
  logic [ID_BITS-1:0] rd_q;
  logic [ID_BITS-1:0] wr_data;
  logic               in_cap;
  logic               id_nz;
  logic               match;

  assign in_cap = salru_pkg::CapW'(IDX) < cap_i;
  assign id_nz  = id_i != '0;
  assign match  = in_cap && id_nz && (rd_q == id_i);
  assign seen_o = seen_i | match;
  assign data_o = rd_q;

  // No match further up the chain: take the neighbour's slot (shift back one)
  always_comb begin
    if (ctl_i.clear || !in_cap) begin
      wr_data = '0;
    end else if (id_nz && !seen_i) begin
      wr_data = prev_i;
    end else begin
      wr_data = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[addr_i] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[addr_i];
    end
  end

endmodule

@@ sv/set_assoc_lru_hit_miss_model.sv @@
// Top level: set-associative LRU hit/miss model built as a chain of way cells.
//
// Each accepted transaction (start high while busy is low) looks up its id in
// one set and returns hit, the saturating miss count and the done echo. A
// transaction reads, then writes back: the accept edge reads the set's row into
// every way cell, and the following execute cycle compares all ways, ripples the
// "found" flag down the chain and writes the reordered row back; that single
// shared row port per cell sets the pace. The result strobe rises at the end
// of the execute cycle and is high for one cycle; a new start may be taken in
// that same cycle. The receiver cannot stall: every result must be captured on
// its strobe. After reset the block sweeps every set's slot store to empty,
// with busy high; configuration writes are taken throughout.
module set_assoc_lru_hit_miss_model #(
  parameter int unsigned SETS    = 16,
  parameter int unsigned WAYS    = 8,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // transaction request
  input  logic                  start,
  output logic                  busy,
  input  salru_pkg::salru_req_t req_i,
  // result
  output logic                  res_valid_o,
  output salru_pkg::salru_res_t res_o,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned AW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned SetN = 1 << salru_pkg::SetW;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [salru_pkg::WaysW-1:0] ways_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == salru_pkg::RegWaysInUse);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= salru_pkg::WaysReset;
    end else if (cfg_wr) begin
      ways_q <= pwdata[salru_pkg::WaysW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == salru_pkg::RegWaysInUse) begin
      prdata = 32'(ways_q);
    end
  end

  // Effective capacity: 0 acts as 1, anything above the built ways as WAYS
  logic [salru_pkg::CapW-1:0] ways_ext;
  logic [salru_pkg::CapW-1:0] cap;

  assign ways_ext = salru_pkg::CapW'(ways_q);

  always_comb begin
    if (ways_ext == '0) begin
      cap = salru_pkg::CapW'(1);
    end else if (ways_ext > salru_pkg::CapW'(WAYS)) begin
      cap = salru_pkg::CapW'(WAYS);
    end else begin
      cap = ways_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Set index folding: out-of-range sets wrap modulo SETS (constant table)
  // ---------------------------------------------------------------------------
  logic [AW-1:0] set_map [SetN];

  for (genvar g = 0; g < SetN; g++) begin : g_set_map
    assign set_map[g] = AW'(g % SETS);
  end

  // ---------------------------------------------------------------------------
  // Sequencer: clearing sweep, idle, execute
  // ---------------------------------------------------------------------------
  salru_pkg::salru_state_e state_q, state_d;
  logic [AW-1:0]           clr_cnt_q, clr_cnt_d;
  logic                    clr_last;
  logic                    accept;

  assign clr_last = clr_cnt_q == AW'(SETS - 1);
  assign accept   = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      salru_pkg::ST_CLEAR: if (clr_last) state_d = salru_pkg::ST_IDLE;
      salru_pkg::ST_IDLE:  if (accept) state_d = salru_pkg::ST_EXEC;
      salru_pkg::ST_EXEC:  state_d = salru_pkg::ST_IDLE;
      default:             state_d = salru_pkg::ST_CLEAR;
    endcase
  end

  salru_pkg::salru_cell_ctl_t ctl;
  logic [AW-1:0]              row_addr;
  logic [AW-1:0]              set_q;

  always_comb begin
    busy      = 1'b1;
    ctl       = '0;
    row_addr  = set_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      salru_pkg::ST_CLEAR: begin
        ctl.wr_en = 1'b1;
        ctl.clear = 1'b1;
        row_addr  = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
      salru_pkg::ST_IDLE: begin
        busy      = 1'b0;
        ctl.rd_en = start;
        row_addr  = set_map[req_i.set_index];
      end
      salru_pkg::ST_EXEC: begin
        ctl.wr_en = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= salru_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Captured transaction; wide ids are masked to ID_BITS here
  logic [ID_BITS-1:0] id_q;
  logic               last_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q   <= ID_BITS'(req_i.access_id);
      set_q  <= set_map[req_i.set_index];
      last_q <= req_i.last_access;
    end
  end

  // ---------------------------------------------------------------------------
  // Way chain: slot 0 is most recent; data and "found" flag ripple down
  // ---------------------------------------------------------------------------
  logic [ID_BITS-1:0] chain_data [WAYS];
  logic [WAYS:0]      chain_seen;

  assign chain_seen[0] = 1'b0;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic [ID_BITS-1:0] prev;
    if (w == 0) begin : g_head
      assign prev = id_q;
    end else begin : g_body
      assign prev = chain_data[w-1];
    end

    salru_cell #(
      .SETS    (SETS),
      .ID_BITS (ID_BITS),
      .IDX     (w),
      .AW      (AW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .addr_i (row_addr),
      .id_i   (id_q),
      .cap_i  (cap),
      .prev_i (prev),
      .seen_i (chain_seen[w]),
      .data_o (chain_data[w]),
      .seen_o (chain_seen[w+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Miss counter and result register
  // ---------------------------------------------------------------------------
  logic                         hit;
  logic [salru_pkg::MissW-1:0]  miss_q, miss_d;
  logic                         exec;

  assign hit  = chain_seen[WAYS];
  assign exec = state_q == salru_pkg::ST_EXEC;

  // Saturates rather than wrapping
  assign miss_d = (hit || miss_q == salru_pkg::MissMax) ? miss_q
                                                        : miss_q + salru_pkg::MissW'(1);

  logic                  res_valid_q;
  salru_pkg::salru_res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= exec;
      if (exec) begin
        miss_q <= miss_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_q.hit        <= hit;
      res_q.miss_total <= miss_d;
      res_q.done_res   <= last_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ sv/salru_checker.sv @@
// Port-level checker for the LRU hit/miss model, bound to the top level.
module salru_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  res_valid_o,
  input salru_pkg::salru_res_t res_o
);

  // Every accepted transaction yields its result once its execute cycle is done
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 res_valid_o)
    else $error("no result two cycles after an accepted transaction");

  // Results never come on consecutive cycles
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe high on two consecutive cycles");

  // The block is free again while a result is shown
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("busy while result strobe is high");

  // A miss always leaves a nonzero, saturating count
  a_miss_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.hit) |-> (res_o.miss_total != '0))
    else $error("miss reported with zero miss count");

endmodule

bind set_assoc_lru_hit_miss_model salru_checker u_salru_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

@@ tb/sv/tb_set_assoc_lru_hit_miss_model.sv @@
// Self-checking testbench for the set-associative LRU hit/miss model.
module tb_set_assoc_lru_hit_miss_model;
  timeunit 1ns;
  timeprecision 1ps;

  import salru_pkg::*;

  // Geometry of the instance under test; the predictor is built to the same size
  localparam int unsigned NumSets = 16;
  localparam int unsigned NumWays = 8;
  localparam int unsigned IdBits  = 16;

  // Byte address of the capacity register (register index times four)
  localparam logic [2:0] WaysInUseAddr = 3'(4 * int'(RegWaysInUse));

  // Cycles with no transaction accepted and no result seen before giving up.
  // The longest sender gap and the post-reset sweep are both far shorter, so
  // this is many times what the slowest correct run needs.
  localparam int unsigned StallLimit = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  salru_req_t req_i;
  logic       res_valid_o;
  salru_res_t res_o;
  logic       psel;
  logic       penable;
  logic       pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic       pready;

  // Predictor state: recency-ordered rows, slot 0 most recent, 0 meaning empty
  logic [IdW-1:0]   lru_rows [NumSets][NumWays];
  logic [MissW-1:0] miss_count;
  logic [WaysW-1:0] ways_cfg;

  // Results still owed by the block, oldest first
  salru_res_t pending_results [$];

  int mismatch_count = 0;
  int idle_cycles    = 0;

  set_assoc_lru_hit_miss_model #(
    .SETS   (NumSets),
    .WAYS   (NumWays),
    .ID_BITS(IdBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Capacity in force: a setting of 0 behaves as 1, anything above the built
  // way count behaves as the way count.
  function automatic int capacity_of(input logic [WaysW-1:0] setting);
    if (setting == '0) return 1;
    if (setting > NumWays) return NumWays;
    return int'(setting);
  endfunction

  // Looks the id up in its set, reorders the row and returns the result the
  // block owes for this transaction.
  function automatic salru_res_t lookup_and_update(input salru_req_t item);
    salru_res_t       res;
    int               cap;
    int               pos;
    logic             found;
    logic [IdW-1:0]   id;
    logic [SetW-1:0]  row;
    cap   = capacity_of(ways_cfg);
    id    = item.access_id;
    row   = item.set_index;
    found = 1'b0;
    pos   = 0;
    // Id zero never matches, even though empty slots hold zero
    if (id != '0) begin
      for (int i = 0; i < cap; i++) begin
        if (!found && lru_rows[row][i] == id) begin
          found = 1'b1;
          pos   = i;
        end
      end
    end
    if (found) begin
      // promote to most recent
      for (int i = pos; i > 0; i--) lru_rows[row][i] = lru_rows[row][i-1];
      lru_rows[row][0] = id;
    end else begin
      if (miss_count != MissMax) miss_count++;
      // insert at the front; the least recent entry in capacity drops off.
      // An id of zero is a miss that leaves the row alone.
      if (id != '0) begin
        for (int i = cap - 1; i > 0; i--) lru_rows[row][i] = lru_rows[row][i-1];
        lru_rows[row][0] = id;
      end
    end
    // slots past the capacity are cleared after every access
    for (int i = cap; i < NumWays; i++) lru_rows[row][i] = '0;
    res.hit        = found;
    res.miss_total = miss_count;
    res.done_res   = item.last_access;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // The receiver cannot stall, so every strobe is a result to be taken now
  always @(posedge clk_i) begin : check_results
    salru_res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction outstanding", '0, res_o.miss_total);
      end else begin
        want = pending_results.pop_front();
        if (res_o.hit !== want.hit)
          report_mismatch("hit", 32'(want.hit), 32'(res_o.hit));
        if (res_o.miss_total !== want.miss_total)
          report_mismatch("miss_total", want.miss_total, res_o.miss_total);
        if (res_o.done_res !== want.done_res)
          report_mismatch("done_res", 32'(want.done_res), 32'(res_o.done_res));
      end
    end
  end

  // Ends the run if neither side makes progress for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("[%0t] watchdog: no progress for %0d cycles", $realtime, StallLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one transaction and holds it until the block takes it. start is
  // left high so a following call goes out back to back.
  task automatic send_access(input logic [IdW-1:0] id, input logic [SetW-1:0] set_sel,
                             input logic last);
    salru_req_t item;
    item.access_id   = id;
    item.set_index   = set_sel;
    item.last_access = last;
    req_i <= item;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(lookup_and_update(item));
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly back to back or short, now and then a long hole
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drops start and lets every outstanding transaction complete
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the capacity register with the block idle and reads it back
  task automatic set_capacity(input logic [WaysW-1:0] setting);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WaysInUseAddr;
    pwdata  <= 32'(setting);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ways_cfg = setting;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    paddr   <= WaysInUseAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[WaysW-1:0] !== setting)
      report_mismatch("ways_in_use read-back", 32'(setting), 32'(prdata[WaysW-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Lowest and highest ids in the first and last sets, with an immediate
  // same-set repeat right after the row's write-back.
  task automatic test_id_extremes();
    send_access(16'h0001, 4'd0, 1'b0);
    send_access(16'h0001, 4'd0, 1'b0);
    send_access(16'hFFFF, 4'd15, 1'b1);
    pause(2);
    send_access(16'hFFFF, 4'd15, 1'b0);
  endtask

  // Id zero: always a miss, never touches the row
  task automatic test_id_zero();
    send_access(16'h0000, 4'd0, 1'b0);
    send_access(16'h0001, 4'd0, 1'b1);
  endtask

  // Fill four entries, shrink to two: the entry in slot 1 still hits, the one
  // that fell past the new capacity is gone.
  task automatic test_capacity_trim();
    send_access(16'h0A01, 4'd3, 1'b0);
    send_access(16'h0A02, 4'd3, 1'b0);
    send_access(16'h0A03, 4'd3, 1'b0);
    send_access(16'h0A04, 4'd3, 1'b0);
    set_capacity(4'd2);
    send_access(16'h0A03, 4'd3, 1'b0);
    send_access(16'h0A02, 4'd3, 1'b0);
  endtask

  // Full set at capacity two: each miss drops the least recent entry
  task automatic test_lru_eviction();
    send_access(16'h0A01, 4'd3, 1'b0);
    pause(1);
    send_access(16'h0A03, 4'd3, 1'b0);
    send_access(16'h0A01, 4'd3, 1'b1);
  endtask

  // Capacity 0 behaves as a single way
  task automatic test_capacity_floor();
    set_capacity(4'd0);
    send_access(16'h1234, 4'd5, 1'b0);
    send_access(16'h1234, 4'd5, 1'b0);
    send_access(16'h4321, 4'd5, 1'b0);
    send_access(16'h1234, 4'd5, 1'b0);
  endtask

  // Capacity 15 is clamped to the built way count
  task automatic test_capacity_ceiling();
    set_capacity(4'd15);
    send_access(16'h2001, 4'd9, 1'b0);
    send_access(16'h2002, 4'd9, 1'b0);
    send_access(16'h2003, 4'd9, 1'b0);
    send_access(16'h2001, 4'd9, 1'b1);
  endtask

  // One phase of random traffic at a fixed capacity. Ids come mostly from a
  // pool a little larger than the capacity and sets from a narrow window, so
  // hits, promotions and evictions all happen often; the rest is id zero and
  // ids from the whole range.
  task automatic run_traffic_phase(input logic [WaysW-1:0] setting, input int n_items);
    logic [IdW-1:0]  id_pool [12];
    logic [IdW-1:0]  id;
    logic [SetW-1:0] set_sel;
    int              pool_n;
    int              base_set;
    int              span;
    int              r;
    logic            bursty;
    set_capacity(setting);
    pool_n   = capacity_of(setting) + $urandom_range(1, 4);
    base_set = $urandom_range(0, NumSets - 1);
    span     = $urandom_range(1, 3);
    bursty   = 1'b0;
    for (int i = 0; i < 12; i++) id_pool[i] = IdW'($urandom_range(1, 16'hFFFF));
    for (int i = 0; i < n_items; i++) begin
      // alternate stretches of back-to-back traffic with gappy ones
      if (i % 25 == 0) bursty = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 5)       id = '0;
      else if (r < 15) id = IdW'($urandom_range(1, 16'hFFFF));
      else             id = id_pool[$urandom_range(0, pool_n - 1)];
      set_sel = SetW'(base_set + $urandom_range(0, span - 1));
      send_access(id, set_sel, ($urandom_range(0, 19) == 0));
      if (!bursty) pause(pick_gap());
    end
  endtask

  // Capacities swept through the phases, extremes included
  task automatic test_random_traffic();
    logic [WaysW-1:0] sweep [11] = '{4'd8, 4'd1, 4'd15, 4'd4, 4'd0, 4'd2,
                                     4'd7, 4'd5, 4'd3, 4'd6, 4'd8};
    foreach (sweep[p]) run_traffic_phase(sweep[p], 50);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    req_i   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    // predictor starts from the reset state: empty store, zero misses
    foreach (lru_rows[s, w]) lru_rows[s][w] = '0;
    miss_count = '0;
    ways_cfg   = WaysReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the block sweeps its store with busy high first; send_access waits it out
    test_id_extremes();
    test_id_zero();
    test_capacity_trim();
    test_lru_eviction();
    test_capacity_floor();
    test_capacity_ceiling();
    test_random_traffic();

    // drain, then wait for a stray strobe
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
